// ===== sv/fcl_pkg.sv =====
`timescale 1ns / 1ps

package fcl_pkg;

	// Framing and sizing
	localparam int MAX_FRAME   = 30;
	localparam int SAMPLE_BITS = 12;
	localparam int LEN_W       = $clog2(MAX_FRAME);
	localparam int TICK_W      = 24;

	// Stream payload widths, rounded up to whole bytes
	localparam int S_DATA_W = ((8 + SAMPLE_BITS + 7) / 8) * 8;
	localparam int M_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

	// Character codes
	localparam logic [7:0] START_MARK = 8'h21;  // '!'
	localparam logic [7:0] END_MARK   = 8'h23;  // '#'

	localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(3000);

	// Item operation codes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Result kinds
	localparam logic KIND_BREAK  = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// Event passed from the deframer to the command executor
	typedef enum logic [1:0] {
		EV_TICK,
		EV_RST,
		EV_OK
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t               kind;
		logic [SAMPLE_BITS-1:0] sample;
	} event_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Expected bytes of "RST"
	function automatic logic [7:0] rst_char(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0:    c = 8'h52;
			2'd1:    c = 8'h53;
			2'd2:    c = 8'h54;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Expected bytes of "OK"
	function automatic logic [7:0] ok_char(input logic idx);
		return idx ? 8'h4B : 8'h4F;
	endfunction

endpackage

// ===== sv/fcl_front.sv =====
`timescale 1ns / 1ps

module fcl_front import fcl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,      // item accepted this cycle
	input  logic                   operation,
	input  logic [7:0]             rx_byte,
	input  logic [SAMPLE_BITS-1:0] adc_sample,
	output logic                   ev_valid,
	output event_t                 ev
);

	logic             in_frame_q;
	logic [LEN_W-1:0] len_q;
	logic [1:0]       match_q;   // bit 0: still "RST" prefix, bit 1: still "OK" prefix

	logic             is_rst;
	logic             is_ok;
	logic             rst_miss;
	logic             ok_miss;
	logic [LEN_W-1:0] len_nx;

	// Classify the incoming byte against the command words
	always_comb begin
		is_rst   = match_q[0] && (len_q == LEN_W'(3));
		is_ok    = match_q[1] && (len_q == LEN_W'(2));
		rst_miss = (len_q >= LEN_W'(3)) || (rx_byte != rst_char(len_q[1:0]));
		ok_miss  = (len_q >= LEN_W'(2)) || (rx_byte != ok_char(len_q[0]));
		len_nx   = len_q + LEN_W'(1);
	end

	// Emit an event for a tick or for a closed, recognized command
	always_comb begin
		ev_valid   = 1'b0;
		ev.kind    = EV_TICK;
		ev.sample  = adc_sample;
		if (take) begin
			if (operation == OP_TICK) begin
				ev_valid = 1'b1;
			end else if (in_frame_q && rx_byte == END_MARK) begin
				if (is_rst) begin
					ev_valid = 1'b1;
					ev.kind  = EV_RST;
				end else if (is_ok) begin
					ev_valid = 1'b1;
					ev.kind  = EV_OK;
				end
			end
		end
	end

	// Track frame state across bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			len_q      <= '0;
			match_q    <= '0;
		end else if (take && operation == OP_BYTE) begin
			if (!in_frame_q) begin
				if (rx_byte == START_MARK) begin
					in_frame_q <= 1'b1;
					len_q      <= '0;
					match_q    <= 2'b11;
				end
			end else if (rx_byte == END_MARK) begin
				in_frame_q <= 1'b0;
			end else begin
				match_q <= match_q & ~{ok_miss, rst_miss};
				len_q   <= len_nx;
				// drop an overlong frame
				if (len_nx >= LEN_W'(MAX_FRAME - 1))
					in_frame_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/fcl_queue.sv =====
`timescale 1ns / 1ps

module fcl_queue import fcl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  event_t push_ev,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output event_t head
);

	event_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	logic do_pop;

	assign full   = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty  = (cnt_q == '0);
	assign head   = slot_q[rd_q];
	assign do_pop = pop && !empty;

	// Store pushed events
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_ev;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPTR_W'(1);
			if (do_pop)
				rd_q <= rd_q + QPTR_W'(1);
			if (push && !do_pop)
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (!push && do_pop)
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

endmodule

// ===== sv/fcl_back.sv =====
`timescale 1ns / 1ps

module fcl_back import fcl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [TICK_W-1:0]      cfg_wdata,
	input  logic                   ev_empty,
	input  event_t                 ev,
	output logic                   ev_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   out_kind,
	output logic [SAMPLE_BITS-1:0] out_value,
	output logic                   out_last
);

	logic [TICK_W-1:0]      timeout_q;
	logic                   awaiting_q;
	logic [TICK_W-1:0]      elapsed_q;
	logic [SAMPLE_BITS-1:0] held_q;
	logic                   pend_q;     // report still owed after a line break

	logic                   out_valid_q;
	logic                   kind_q;
	logic [SAMPLE_BITS-1:0] value_q;
	logic                   last_q;

	logic can_load;

	assign can_load  = !out_valid_q || out_ready;
	assign ev_pop    = can_load && !pend_q && !ev_empty;
	assign out_valid = out_valid_q;
	assign out_kind  = kind_q;
	assign out_value = value_q;
	assign out_last  = last_q;

	// Hold the timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			timeout_q <= TIMEOUT_RESET;
		else if (cfg_we)
			timeout_q <= cfg_wdata;
	end

	// Execute events and drive the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q  <= 1'b0;
			elapsed_q   <= '0;
			held_q      <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_BREAK;
			value_q     <= '0;
			last_q      <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= 1'b0;
			if (pend_q) begin
				pend_q      <= 1'b0;
				out_valid_q <= 1'b1;
				kind_q      <= KIND_REPORT;
				value_q     <= held_q;
				last_q      <= 1'b1;
			end else if (!ev_empty) begin
				unique case (ev.kind)
					EV_TICK: begin
						if (awaiting_q) begin
							if (elapsed_q >= timeout_q) begin
								elapsed_q   <= '0;
								out_valid_q <= 1'b1;
								kind_q      <= KIND_REPORT;
								value_q     <= held_q;
								last_q      <= 1'b1;
							end else begin
								elapsed_q <= elapsed_q + TICK_W'(1);
							end
						end
					end
					EV_RST: begin
						if (!awaiting_q) begin
							held_q      <= ev.sample;
							awaiting_q  <= 1'b1;
							elapsed_q   <= '0;
							pend_q      <= 1'b1;
							out_valid_q <= 1'b1;
							kind_q      <= KIND_BREAK;
							value_q     <= '0;
							last_q      <= 1'b0;
						end
					end
					EV_OK: begin
						if (awaiting_q)
							awaiting_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ===== sv/framed_command_link_with_ack_timeout.sv =====
`timescale 1ns / 1ps

// Framed command link with acknowledge timeout. Each input item is a received
// byte or a time tick. Bytes between '!' and '#' form a command; a frame whose
// body reaches MAX_FRAME-1 bytes is dropped. In idle, "RST" yields a line-break
// result (tlast low) and then a report of the sample sent with the closing '#'
// (tlast high), and the link waits for "OK". While waiting, a tick that finds
// timeout_ticks ticks elapsed resends the held sample and restarts the count.
// Items are taken one per clock while the four-entry queue from the deframer to
// the executor has room; the executor retires one event per clock, but pauses
// after "RST" for its second result; otherwise it stalls only on a held output.
module framed_command_link_with_ack_timeout import fcl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// configuration: timeout_ticks
	input  logic                cfg_we,
	input  logic [TICK_W-1:0]   cfg_wdata,
	// input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // rx_byte, adc_sample, zero fill
	input  logic                s_tuser,   // operation
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // report_value, zero fill
	output logic                m_tuser,   // kind
	output logic                m_tlast
);

	logic                   take;
	logic                   ev_valid;
	event_t                 ev_in;
	event_t                 ev_head;
	logic                   q_full;
	logic                   q_empty;
	logic                   ev_pop;
	logic [SAMPLE_BITS-1:0] out_value;

	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;

	fcl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.operation  (s_tuser),
		.rx_byte    (s_tdata[7:0]),
		.adc_sample (s_tdata[8 +: SAMPLE_BITS]),
		.ev_valid   (ev_valid),
		.ev         (ev_in)
	);

	fcl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (ev_valid),
		.push_ev (ev_in),
		.full    (q_full),
		.pop     (ev_pop),
		.empty   (q_empty),
		.head    (ev_head)
	);

	fcl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ev_empty  (q_empty),
		.ev        (ev_head),
		.ev_pop    (ev_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_value (out_value),
		.out_last  (m_tlast)
	);

	assign m_tdata = M_DATA_W'(out_value);

endmodule
